>>> hw/rtl/mafs_pkg.sv
package mafs_pkg;

	// Widths of ports and storage
	localparam int TIME_W_DEFAULT = 48;
	localparam int OUT_TIME_W     = 48;
	localparam int SKIP_W         = 29;
	localparam int SIZE_W         = 11;
	localparam int FILL_W         = 3;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 48;

	// Divider and header arithmetic widths
	localparam int DIVIDEND_W = 27;
	localparam int DIVISOR_W  = 16;
	localparam int KBPS_W     = 9;
	localparam int DUR_W      = 24;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LEADING_SKIP = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME   = CFG_INDEX_W'(1);

	// Frame length and duration coefficients
	localparam int BPS_PER_KBPS  = 1000;
	localparam int SLOT_COEF_V1  = 144;
	localparam int TICKS_PER_SEC = 10000000;
	localparam int LEN_COEF_V1   = SLOT_COEF_V1 * BPS_PER_KBPS;
	localparam int LEN_COEF_LSF  = LEN_COEF_V1 / 2;
	// ticks * len / (kbps * 1000 / 8) == len * DUR_COEF / kbps
	localparam int DUR_COEF      = TICKS_PER_SEC * 8 / BPS_PER_KBPS;
	localparam int HDR_BYTES     = 4;

	// Header field codes
	localparam logic [7:0] SYNC_BYTE    = 8'hff;
	localparam logic [2:0] SYNC_TOP     = 3'h7;
	localparam logic [1:0] LAYER_III    = 2'b01;
	localparam logic [1:0] VER_MPEG25   = 2'b00;
	localparam logic [1:0] VER_RESERVED = 2'b01;
	localparam logic [1:0] VER_MPEG2    = 2'b10;
	localparam logic [1:0] VER_MPEG1    = 2'b11;
	localparam logic [3:0] BR_FREE      = 4'd0;
	localparam logic [3:0] BR_BAD       = 4'd15;
	localparam logic [1:0] FR_RESERVED  = 2'd3;
	localparam logic [FILL_W-1:0] WINDOW_FULL = FILL_W'(HDR_BYTES);

	typedef struct packed {
		logic       run;
		logic       div_start_len;
		logic       div_start_dur;
		logic       len_done;
		logic       dur_done;
		logic       hdr_load;
		logic [1:0] hdr_idx;
	} mafs_cmd_t;

	typedef struct packed {
		logic hit;
		logic div_done;
		logic slot_free;
	} mafs_sts_t;

	// Layer III header acceptance on a 4-byte window, first byte on top
	function automatic logic header_ok(input logic [31:0] w);
		logic ok;
		begin
			ok = (w[31:24] == SYNC_BYTE) && (w[23:21] == SYNC_TOP) &&
				(w[18:17] == LAYER_III) && (w[20:19] != VER_RESERVED) &&
				(w[15:12] != BR_FREE) && (w[15:12] != BR_BAD) &&
				(w[11:10] != FR_RESERVED);
			return ok;
		end
	endfunction

	function automatic logic [KBPS_W-1:0] kbps_of(input logic [1:0] ver, input logic [3:0] br);
		logic [KBPS_W-1:0] k;
		begin
			if (ver == VER_MPEG1) begin
				case (br)
					4'd1: k = 9'd32;
					4'd2: k = 9'd40;
					4'd3: k = 9'd48;
					4'd4: k = 9'd56;
					4'd5: k = 9'd64;
					4'd6: k = 9'd80;
					4'd7: k = 9'd96;
					4'd8: k = 9'd112;
					4'd9: k = 9'd128;
					4'd10: k = 9'd160;
					4'd11: k = 9'd192;
					4'd12: k = 9'd224;
					4'd13: k = 9'd256;
					4'd14: k = 9'd320;
					default: k = 9'd0;
				endcase
			end else begin
				case (br)
					4'd1: k = 9'd8;
					4'd2: k = 9'd16;
					4'd3: k = 9'd24;
					4'd4: k = 9'd32;
					4'd5: k = 9'd40;
					4'd6: k = 9'd48;
					4'd7: k = 9'd56;
					4'd8: k = 9'd64;
					4'd9: k = 9'd80;
					4'd10: k = 9'd96;
					4'd11: k = 9'd112;
					4'd12: k = 9'd128;
					4'd13: k = 9'd144;
					4'd14: k = 9'd160;
					default: k = 9'd0;
				endcase
			end
			return k;
		end
	endfunction

	function automatic logic [DIVISOR_W-1:0] hz_of(input logic [1:0] ver, input logic [1:0] fr);
		logic [DIVISOR_W-1:0] h;
		begin
			case ({ver, fr})
				{VER_MPEG1, 2'd0}: h = 16'd44100;
				{VER_MPEG1, 2'd1}: h = 16'd48000;
				{VER_MPEG1, 2'd2}: h = 16'd32000;
				{VER_MPEG2, 2'd0}: h = 16'd22050;
				{VER_MPEG2, 2'd1}: h = 16'd24000;
				{VER_MPEG2, 2'd2}: h = 16'd16000;
				{VER_MPEG25, 2'd0}: h = 16'd11025;
				{VER_MPEG25, 2'd1}: h = 16'd12000;
				{VER_MPEG25, 2'd2}: h = 16'd8000;
				default: h = 16'd8000;
			endcase
			return h;
		end
	endfunction

endpackage

>>> hw/rtl/mafs_if.sv
interface mafs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface mafs_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        frame_first;
	logic        frame_last;
	logic [47:0] frame_begin_time;
	logic [47:0] frame_end_time;
	logic [10:0] frame_size;

	modport source(output valid, output out_byte, output frame_first, output frame_last,
		output frame_begin_time, output frame_end_time, output frame_size, input ready);
	modport sink(input valid, input out_byte, input frame_first, input frame_last,
		input frame_begin_time, input frame_end_time, input frame_size, output ready);
endinterface

interface mafs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/mafs_div.sv
module mafs_div
	import mafs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// One quotient bit per cycle, restoring form
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend into remainder, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(DIVIDEND_W + 1) done_q)
		else $error("divider did not finish on time");

endmodule

>>> hw/rtl/mafs_ctrl.sv
module mafs_ctrl
	import mafs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mafs_sts_t sts,
	output mafs_cmd_t cmd
);

	localparam logic [2:0] ST_RUN      = 3'd0;
	localparam logic [2:0] ST_LEN_GO   = 3'd1;
	localparam logic [2:0] ST_LEN_WAIT = 3'd2;
	localparam logic [2:0] ST_DUR_GO   = 3'd3;
	localparam logic [2:0] ST_DUR_WAIT = 3'd4;
	localparam logic [2:0] ST_HDR      = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] hdr_cnt_q, hdr_cnt_d;

	// Next state and commands
	always_comb begin
		cmd         = '0;
		cmd.hdr_idx = hdr_cnt_q;
		state_d     = state_q;
		hdr_cnt_d   = hdr_cnt_q;
		case (state_q)
			ST_RUN: begin
				cmd.run = 1'b1;
				if (sts.hit) state_d = ST_LEN_GO;
			end
			ST_LEN_GO: begin
				cmd.div_start_len = 1'b1;
				state_d = ST_LEN_WAIT;
			end
			ST_LEN_WAIT: begin
				if (sts.div_done) begin
					cmd.len_done = 1'b1;
					state_d = ST_DUR_GO;
				end
			end
			ST_DUR_GO: begin
				cmd.div_start_dur = 1'b1;
				state_d = ST_DUR_WAIT;
			end
			ST_DUR_WAIT: begin
				if (sts.div_done) begin
					cmd.dur_done = 1'b1;
					hdr_cnt_d = 2'd0;
					state_d = ST_HDR;
				end
			end
			ST_HDR: begin
				if (sts.slot_free) begin
					cmd.hdr_load = 1'b1;
					hdr_cnt_d = hdr_cnt_q + 2'd1;
					if (hdr_cnt_q == 2'(HDR_BYTES - 1)) state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			hdr_cnt_q <= 2'd0;
		end else begin
			state_q   <= state_d;
			hdr_cnt_q <= hdr_cnt_d;
		end
	end

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_LEN_WAIT || state_q == ST_DUR_WAIT))
		else $error("divider finished outside a wait state");

endmodule

>>> hw/rtl/mafs_dp.sv
module mafs_dp
	import mafs_pkg::*;
#(
	parameter int TIME_W = TIME_W_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mafs_cmd_t     cmd,
	output mafs_sts_t     sts,
	mafs_byte_if.sink     bytes,
	mafs_frame_if.source  frames,
	mafs_cfg_if.sink      cfg
);

	logic [SKIP_W-1:0] skip_left_q;
	logic [31:0]       window_q;
	logic [FILL_W-1:0] fill_q;
	logic              in_frame_q;
	logic [SIZE_W-1:0] bytes_left_q;
	logic [SIZE_W-1:0] size_q;
	logic [TIME_W-1:0] running_q;
	logic [TIME_W-1:0] origin_q;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_first_q;
	logic                  out_last_q;
	logic [OUT_TIME_W-1:0] out_begin_q;
	logic [OUT_TIME_W-1:0] out_end_q;
	logic [SIZE_W-1:0]     out_size_q;

	logic                  accept;
	logic                  slot_free;
	logic                  skipping;
	logic                  pay_load;
	logic                  load;
	logic                  hunt;
	logic [31:0]           window_next;
	logic [FILL_W-1:0]     fill_next;
	logic [SIZE_W-1:0]     bytes_left_next;
	logic [1:0]            ver;
	logic                  lsf;
	logic [KBPS_W-1:0]     kbps;
	logic [DIVIDEND_W-1:0] kbps_ext;
	logic [DIVIDEND_W-1:0] len_coef;
	logic [DIVIDEND_W-1:0] len_dividend;
	logic [DIVIDEND_W-1:0] dur_dividend;
	logic [DIVIDEND_W-1:0] quotient;
	logic                  div_done;
	logic [SIZE_W-1:0]     len;
	logic [TIME_W-1:0]     dur_ext;
	logic [7:0]            hdr_byte;
	logic [7:0]            sel_byte;
	logic                  sel_first;
	logic                  sel_last;
	logic [TIME_W+OUT_TIME_W-1:0] origin_wide;
	logic [TIME_W+OUT_TIME_W-1:0] running_wide;
	logic [TIME_W+CFG_DATA_W-1:0] start_wide;

	// Input handshake
	assign slot_free   = !out_valid_q || frames.ready;
	assign bytes.ready = cmd.run && (!in_frame_q || slot_free);
	assign accept      = bytes.valid && bytes.ready;
	assign skipping    = skip_left_q != '0;
	assign pay_load    = accept && !skipping && in_frame_q;
	assign hunt        = accept && !skipping && !in_frame_q;
	assign cfg.ready   = 1'b1;

	// Sliding header window
	assign window_next     = {window_q[23:0], bytes.data_byte};
	assign fill_next       = (fill_q < WINDOW_FULL) ? fill_q + 1'b1 : fill_q;
	assign bytes_left_next = bytes_left_q - 1'b1;

	assign sts.hit       = hunt && (fill_next == WINDOW_FULL) && header_ok(window_next);
	assign sts.div_done  = div_done;
	assign sts.slot_free = slot_free;

	// Divider operands from the held header
	assign ver      = window_q[20:19];
	assign lsf      = ver != VER_MPEG1;
	assign kbps     = kbps_of(ver, window_q[15:12]);
	assign kbps_ext = DIVIDEND_W'(kbps);
	assign len_coef = lsf ? DIVIDEND_W'(LEN_COEF_LSF) : DIVIDEND_W'(LEN_COEF_V1);
	assign len_dividend = kbps_ext * len_coef;
	assign dur_dividend = DIVIDEND_W'(size_q) * DIVIDEND_W'(DUR_COEF);

	mafs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start_len || cmd.div_start_dur),
		.dividend (cmd.div_start_len ? len_dividend : dur_dividend),
		.divisor  (cmd.div_start_len ? hz_of(ver, window_q[11:10]) : DIVISOR_W'(kbps)),
		.done     (div_done),
		.quotient (quotient)
	);

	assign len     = quotient[SIZE_W-1:0] + SIZE_W'(window_q[9]);
	assign dur_ext = TIME_W'(quotient[DUR_W-1:0]);

	assign start_wide   = {{TIME_W{1'b0}}, cfg.data};
	assign origin_wide  = {{OUT_TIME_W{1'b0}}, origin_q};
	assign running_wide = {{OUT_TIME_W{1'b0}}, running_q};

	// Stream state, header bookkeeping and running time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_left_q  <= '0;
			window_q     <= '0;
			fill_q       <= '0;
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
			size_q       <= '0;
			running_q    <= '0;
			origin_q     <= '0;
		end else begin
			if (accept && skipping) skip_left_q <= skip_left_q - 1'b1;
			if (pay_load) begin
				bytes_left_q <= bytes_left_next;
				if (bytes_left_next == '0) in_frame_q <= 1'b0;
			end
			if (hunt) begin
				window_q <= window_next;
				fill_q   <= sts.hit ? '0 : fill_next;
			end
			if (cmd.len_done) begin
				size_q       <= len;
				bytes_left_q <= len - SIZE_W'(HDR_BYTES);
				in_frame_q   <= len != SIZE_W'(HDR_BYTES);
			end
			if (cmd.dur_done) begin
				origin_q  <= running_q;
				running_q <= running_q + dur_ext;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_LEADING_SKIP: skip_left_q <= cfg.data[SKIP_W-1:0];
					CFG_START_TIME:   running_q <= start_wide[TIME_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Pick a header byte, first byte on top
	always_comb begin
		case (cmd.hdr_idx)
			2'd0: hdr_byte = window_q[31:24];
			2'd1: hdr_byte = window_q[23:16];
			2'd2: hdr_byte = window_q[15:8];
			default: hdr_byte = window_q[7:0];
		endcase
	end

	assign load      = pay_load || cmd.hdr_load;
	assign sel_byte  = cmd.hdr_load ? hdr_byte : bytes.data_byte;
	assign sel_first = cmd.hdr_load && (cmd.hdr_idx == 2'd0);
	assign sel_last  = cmd.hdr_load ? ((cmd.hdr_idx == 2'(HDR_BYTES - 1)) && !in_frame_q)
		: (bytes_left_next == '0);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= sel_byte;
			out_first_q <= sel_first;
			out_last_q  <= sel_last;
			out_begin_q <= origin_wide[OUT_TIME_W-1:0];
			out_end_q   <= running_wide[OUT_TIME_W-1:0];
			out_size_q  <= size_q;
		end
	end

	assign frames.valid            = out_valid_q;
	assign frames.out_byte         = out_byte_q;
	assign frames.frame_first      = out_first_q;
	assign frames.frame_last       = out_last_q;
	assign frames.frame_begin_time = out_begin_q;
	assign frames.frame_end_time   = out_end_q;
	assign frames.frame_size       = out_size_q;

	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pay_load && bytes_left_q == SIZE_W'(1)) |=> !in_frame_q)
		else $error("frame did not close on its last byte");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dur_done |-> (size_q >= SIZE_W'(24) && size_q <= SIZE_W'(1441)))
		else $error("frame length out of range");

endmodule

>>> hw/rtl/mpeg_audio_frame_sync.sv
// Channel  Role    Handshake      Payload
// bytes    sink    valid/ready    data_byte[7:0]
// frames   source  valid/ready    out_byte, frame_first, frame_last,
//                                 frame_begin_time, frame_end_time, frame_size
// cfg      sink    valid/ready    index[1:0], data[47:0] (ready always high)
//
// Bytes are taken while running; inside a frame, only when the output is free.
// A header stalls input during two passes of the one-bit-per-cycle divider (frame
// length, then duration), each a start, 27 quotient bits and done, and while the
// four header bytes go out; a held output adds its stall.
// A registered output stage holds a result while the next byte is taken.
// Reset clears all control state; the running time resets to zero.
module mpeg_audio_frame_sync
	import mafs_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_W_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	mafs_byte_if.sink    bytes,
	mafs_frame_if.source frames,
	mafs_cfg_if.sink     cfg
);

	mafs_cmd_t cmd;
	mafs_sts_t sts;

	mafs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mafs_dp #(
		.TIME_W (TIME_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.bytes  (bytes),
		.frames (frames),
		.cfg    (cfg)
	);

endmodule

>>> verif/tb_mpeg_audio_frame_sync.sv
`timescale 1ns / 100ps

module tb_mpeg_audio_frame_sync;
	import mafs_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 128;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int BROKEN_KINDS  = 7;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = CFG_INDEX_W'(3);
	localparam logic [CFG_DATA_W-1:0]  SKIP_MAX    = CFG_DATA_W'(268435465);
	localparam logic [CFG_DATA_W-1:0]  TIME_MAX    = {CFG_DATA_W{1'b1}};

	localparam int unsigned SLOTS_MPEG1  = 144;
	localparam int unsigned SLOTS_LSF    = 72;
	localparam int unsigned BPS_PER_K    = 1000;
	localparam longint unsigned TICKS_1S = 10000000;

	localparam int unsigned KBPS_MPEG1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
		192, 224, 256, 320, 0};
	localparam int unsigned KBPS_LSF [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
		128, 144, 160, 0};
	localparam int unsigned HZ_MPEG1 [3]  = '{44100, 48000, 32000};
	localparam int unsigned HZ_MPEG2 [3]  = '{22050, 24000, 16000};
	localparam int unsigned HZ_MPEG25 [3] = '{11025, 12000, 8000};

	typedef struct {
		logic [7:0]            out_byte;
		logic                  frame_first;
		logic                  frame_last;
		logic [OUT_TIME_W-1:0] frame_begin_time;
		logic [OUT_TIME_W-1:0] frame_end_time;
		logic [SIZE_W-1:0]     frame_size;
	} frame_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mafs_byte_if  bytes_ch();
	mafs_frame_if frames_ch();
	mafs_cfg_if   cfg_ch();

	mpeg_audio_frame_sync dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.frames (frames_ch),
		.cfg    (cfg_ch)
	);

	// Stream bytes waiting for the driver, and frame bytes the block still owes
	logic [7:0]  stream_bytes[$];
	frame_beat_t frame_beats_due[$];
	int          error_count = 0;

	// Tracker copy of the synchronizer state
	logic [31:0]           trk_window = '0;
	int unsigned           trk_fill = 0;
	logic                  trk_in_frame = 1'b0;
	logic [SIZE_W-1:0]     trk_bytes_left = '0;
	logic [SKIP_W-1:0]     trk_skip_left = '0;
	logic [OUT_TIME_W-1:0] trk_now = '0;
	logic [OUT_TIME_W-1:0] trk_origin = '0;
	logic [SIZE_W-1:0]     trk_size = '0;

	// Sender and receiver pacing
	int unsigned tx_burst_left = 0;
	int unsigned tx_gap_left = 0;
	int unsigned rx_hold_left = 0;
	logic        rx_ready_next = 1'b0;
	frame_beat_t seen_beat;
	frame_beat_t due_beat;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Frame length in bytes of a layer III header, zero when the window holds none
	function automatic int unsigned header_frame_len(input logic [31:0] w,
		output longint unsigned ticks);
		logic [1:0]      ver;
		logic            lsf;
		int unsigned     kbps;
		int unsigned     hz;
		int unsigned     len;
		longint unsigned bps;
		ticks = 0;
		ver = w[20:19];
		if (w[31:24] != SYNC_BYTE || w[23:21] != SYNC_TOP || w[18:17] != LAYER_III ||
			ver == VER_RESERVED || w[15:12] == BR_FREE || w[15:12] == BR_BAD ||
			w[11:10] == FR_RESERVED)
			return 0;
		lsf = (ver != VER_MPEG1);
		kbps = lsf ? KBPS_LSF[w[15:12]] : KBPS_MPEG1[w[15:12]];
		case (ver)
			VER_MPEG1: hz = HZ_MPEG1[w[11:10]];
			VER_MPEG2: hz = HZ_MPEG2[w[11:10]];
			default:   hz = HZ_MPEG25[w[11:10]];
		endcase
		bps = longint'(kbps) * BPS_PER_K;
		len = int'(((lsf ? SLOTS_LSF : SLOTS_MPEG1) * bps) / hz) + w[9];
		ticks = TICKS_1S * len / (bps / 8);
		return len;
	endfunction

	function void owe_beat(input logic [7:0] b, input logic first, input logic last);
		frame_beats_due.push_back('{b, first, last, trk_origin, trk_now, trk_size});
	endfunction

	// Advance the tracker by one accepted stream byte
	function void track_stream_byte(input logic [7:0] b);
		int unsigned     len;
		longint unsigned ticks;
		if (trk_skip_left != 0) begin
			trk_skip_left = trk_skip_left - 1'b1;
			return;
		end
		if (trk_in_frame) begin
			trk_bytes_left = trk_bytes_left - 1'b1;
			if (trk_bytes_left == 0)
				trk_in_frame = 1'b0;
			owe_beat(b, 1'b0, trk_bytes_left == 0);
			return;
		end
		trk_window = {trk_window[23:0], b};
		if (trk_fill < HDR_BYTES)
			trk_fill++;
		if (trk_fill < HDR_BYTES)
			return;
		len = header_frame_len(trk_window, ticks);
		if (len == 0)
			return;
		trk_size = SIZE_W'(len);
		trk_origin = trk_now;
		trk_now = trk_now + ticks[OUT_TIME_W-1:0];
		trk_bytes_left = SIZE_W'(len - HDR_BYTES);
		trk_in_frame = (trk_bytes_left != 0);
		trk_fill = 0;
		for (int k = 0; k < HDR_BYTES; k++)
			owe_beat(trk_window[31 - 8 * k -: 8], k == 0, k == HDR_BYTES - 1 && !trk_in_frame);
	endfunction

	// Drive stream bytes in bursts separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_ch.valid <= 1'b0;
			bytes_ch.data_byte <= '0;
		end else begin
			if (bytes_ch.valid && bytes_ch.ready)
				track_stream_byte(bytes_ch.data_byte);
			if (!bytes_ch.valid || bytes_ch.ready) begin
				if (tx_gap_left != 0) begin
					tx_gap_left--;
					bytes_ch.valid <= 1'b0;
				end else if (stream_bytes.size() != 0) begin
					bytes_ch.valid <= 1'b1;
					bytes_ch.data_byte <= stream_bytes.pop_front();
					if (tx_burst_left <= 1) begin
						tx_burst_left = $urandom_range(1, 48);
						tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						tx_burst_left--;
					end
				end else begin
					bytes_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Check each frame transaction against the oldest owed beat; stall on a random pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_ch.ready <= 1'b0;
		end else begin
			if (frames_ch.valid && frames_ch.ready) begin
				seen_beat = '{frames_ch.out_byte, frames_ch.frame_first, frames_ch.frame_last,
					frames_ch.frame_begin_time, frames_ch.frame_end_time, frames_ch.frame_size};
				if (frame_beats_due.size() == 0) begin
					$error("unexpected frame transaction, out_byte %0h", seen_beat.out_byte);
					error_count++;
				end else begin
					due_beat = frame_beats_due.pop_front();
					if (seen_beat.out_byte !== due_beat.out_byte) begin
						$error("out_byte: expected %0h, actual %0h", due_beat.out_byte,
							seen_beat.out_byte);
						error_count++;
					end
					if (seen_beat.frame_first !== due_beat.frame_first) begin
						$error("frame_first: expected %0b, actual %0b", due_beat.frame_first,
							seen_beat.frame_first);
						error_count++;
					end
					if (seen_beat.frame_last !== due_beat.frame_last) begin
						$error("frame_last: expected %0b, actual %0b", due_beat.frame_last,
							seen_beat.frame_last);
						error_count++;
					end
					if (seen_beat.frame_begin_time !== due_beat.frame_begin_time) begin
						$error("frame_begin_time: expected %0h, actual %0h",
							due_beat.frame_begin_time, seen_beat.frame_begin_time);
						error_count++;
					end
					if (seen_beat.frame_end_time !== due_beat.frame_end_time) begin
						$error("frame_end_time: expected %0h, actual %0h",
							due_beat.frame_end_time, seen_beat.frame_end_time);
						error_count++;
					end
					if (seen_beat.frame_size !== due_beat.frame_size) begin
						$error("frame_size: expected %0d, actual %0d", due_beat.frame_size,
							seen_beat.frame_size);
						error_count++;
					end
				end
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
			end else begin
				rx_ready_next = !rx_ready_next;
				if (rx_ready_next)
					rx_hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) :
						$urandom_range(1, 12);
				else
					rx_hold_left = $urandom_range(1, 6);
			end
			frames_ch.ready <= rx_ready_next;
		end
	end

	function automatic logic [31:0] mp3_header(input logic [1:0] ver, input logic [3:0] br,
		input logic [1:0] fr, input logic pad);
		return {SYNC_BYTE, SYNC_TOP, ver, LAYER_III, 1'($urandom), br, fr, pad, 1'($urandom),
			8'($urandom)};
	endfunction

	// Queue the four header bytes alone, first byte first
	task automatic queue_header(input logic [31:0] hdr);
		for (int k = HDR_BYTES - 1; k >= 0; k--)
			stream_bytes.push_back(hdr[8 * k +: 8]);
	endtask

	// Queue a header and, when it is acceptable on its own, its payload
	task automatic queue_frame(input logic [31:0] hdr);
		int unsigned     len;
		longint unsigned ticks;
		queue_header(hdr);
		len = header_frame_len(hdr, ticks);
		for (int unsigned n = HDR_BYTES; n < len; n++)
			stream_bytes.push_back(8'($urandom));
	endtask

	function automatic logic [1:0] pick_version();
		case ($urandom_range(0, 2))
			0:       return VER_MPEG1;
			1:       return VER_MPEG2;
			default: return VER_MPEG25;
		endcase
	endfunction

	// Lowest MPEG-2 bitrate so that the frame stays short
	task automatic queue_short_frame();
		queue_frame(mp3_header(VER_MPEG2, 4'd1, 2'($urandom_range(0, 2)), 1'($urandom)));
	endtask

	// Queue a header spoiled in one field
	task automatic queue_broken_header(input int unsigned kind);
		logic [31:0] h;
		h = mp3_header(pick_version(), 4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
			1'($urandom));
		case (kind)
			0:       h[31:24] = 8'($urandom_range(0, 254));
			1:       h[23:21] = 3'($urandom_range(0, 6));
			2:       h[20:19] = VER_RESERVED;
			3:       h[18:17] = LAYER_III ^ 2'($urandom_range(1, 3));
			4:       h[15:12] = BR_FREE;
			5:       h[15:12] = BR_BAD;
			default: h[11:10] = FR_RESERVED;
		endcase
		queue_frame(h);
	endtask

	task automatic queue_noise(input int unsigned n);
		repeat (n)
			stream_bytes.push_back(8'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_LEADING_SKIP)
			trk_skip_left = val[SKIP_W-1:0];
		else if (idx == CFG_START_TIME)
			trk_now = val[OUT_TIME_W-1:0];
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold until every byte is taken and every owed beat is back, then let the block settle
	task automatic drain_stream();
		while (stream_bytes.size() != 0 || bytes_ch.valid || frame_beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		bytes_ch.valid = 1'b0;
		bytes_ch.data_byte = '0;
		frames_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Spare register indexes must leave the block untouched
		write_reg(CFG_SPARE_2, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(CFG_SPARE_3, CFG_DATA_W'({$urandom, $urandom}));

		// Directed: partial window with doubled sync, shortest frame, MPEG-2.5 table,
		// then one header spoiled in each field
		stream_bytes.push_back(SYNC_BYTE);
		stream_bytes.push_back(SYNC_BYTE);
		queue_frame(mp3_header(VER_MPEG2, 4'd1, 2'd1, 1'b0));
		queue_frame(mp3_header(VER_MPEG25, 4'd1, 2'd1, 1'b1));
		for (int unsigned kind = 0; kind < BROKEN_KINDS; kind++)
			queue_broken_header(kind);
		drain_stream();

		// A skip far longer than the stream drops everything, including a good header
		write_reg(CFG_LEADING_SKIP, SKIP_MAX);
		write_reg(CFG_START_TIME, TIME_MAX);
		queue_noise(2);
		queue_header(mp3_header(VER_MPEG2, 4'd1, 2'd1, 1'b0));
		drain_stream();

		// Upper data bits beyond the skip width are dropped; the running time wraps
		write_reg(CFG_LEADING_SKIP, 48'hFFFF_E000_0002);
		queue_noise(2);
		queue_frame(mp3_header(VER_MPEG2, 4'd1, 2'd0, 1'b1));
		drain_stream();

		// Random start time and skip, then a spoiled header and a short frame
		write_reg(CFG_START_TIME, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(CFG_LEADING_SKIP, CFG_DATA_W'($urandom_range(0, 2)));
		queue_noise($urandom_range(2, 4));
		queue_broken_header($urandom_range(0, BROKEN_KINDS - 1));
		queue_short_frame();
		drain_stream();

		// Longest frame: the header alone carries its length and duration
		queue_header(mp3_header(VER_MPEG1, 4'd14, 2'd2, 1'b1));
		drain_stream();

		if (frame_beats_due.size() != 0) begin
			$error("frame transactions never delivered: %0d", frame_beats_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("tb_mpeg_audio_frame_sync: done, clean");
		else
			$display("tb_mpeg_audio_frame_sync: done, errors");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("tb_mpeg_audio_frame_sync: done, errors");
		$finish;
	end

endmodule
